[sv/mwo_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwo_pkg
// Shared types and constants of the multi-waveform oscillator.
// ----------------------------------------------------------------------------
package mwo_pkg;

  localparam int FREQ_W  = 20;
  localparam int PHASE_W = 32;
  localparam int LEVEL_W = 16;
  localparam int ROM_W   = 15;

  localparam logic signed [LEVEL_W-1:0] LEVEL_MAX = 16'sh7FFF;
  localparam logic signed [LEVEL_W-1:0] LEVEL_MIN = 16'sh8000;

  // pi/2 in Q30
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // queue depths between the parts
  localparam int MID_DEPTH = 8;
  localparam int OUT_DEPTH = 4;

  // phase step as magnitude and direction
  typedef struct packed {
    logic               neg;
    logic [PHASE_W-1:0] step;
  } step_t;

  typedef struct packed {
    logic signed [LEVEL_W-1:0] saw_level;
    logic signed [LEVEL_W-1:0] sine_level;
    logic signed [LEVEL_W-1:0] square_level;
    logic signed [LEVEL_W-1:0] tri_level;
  } wave_t;

endpackage

[sv/mwo_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwo_fifo
// Small register queue with a fill count; the head is shown combinationally.
// ----------------------------------------------------------------------------
module mwo_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     wr_en,
  input  logic [W-1:0]             wr_data,
  input  logic                     rd_en,
  output logic [W-1:0]             rd_data,
  output logic                     empty,
  output logic [$clog2(DEPTH):0]   count
);

  localparam int PW = $clog2(DEPTH);

  logic [W-1:0]  mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= PW'(wr_ptr + 1'b1);
      end
      if (rd_en) begin
        rd_ptr <= PW'(rd_ptr + 1'b1);
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign rd_data = mem[rd_ptr];
  assign empty   = (count == '0);

endmodule

[sv/mwo_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwo_front
// Turns a signed frequency into a rounded phase step, three register stages.
// ----------------------------------------------------------------------------
module mwo_front
  import mwo_pkg::*;
#(
  parameter int SAMPLE_RATE_HZ = 48000
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_take,
  input  logic signed [FREQ_W-1:0] freq,
  output logic                     step_valid,
  output step_t                    step_item,
  output logic [1:0]               inflight
);

  // step = (mag * 2^28 + SR/2) / SR, split as mag*A + (mag*B + SR/2) / SR
  localparam int          SR_W  = $clog2(SAMPLE_RATE_HZ + 1);
  localparam int          A_VAL = (1 << 28) / SAMPLE_RATE_HZ;
  localparam int          B_VAL = (1 << 28) % SAMPLE_RATE_HZ;
  localparam int          A_W   = $clog2(A_VAL + 1);
  localparam int          B_W   = $clog2(SAMPLE_RATE_HZ);
  localparam int          R_W   = $clog2(3 * SAMPLE_RATE_HZ) + 1;
  localparam logic [A_W-1:0]  A_C   = A_W'(A_VAL);
  localparam logic [B_W-1:0]  B_C   = B_W'(B_VAL);
  localparam logic [SR_W-1:0] SR_C  = SR_W'(SAMPLE_RATE_HZ);
  localparam logic [R_W-1:0]  HALF_C = R_W'(SAMPLE_RATE_HZ / 2);
  localparam logic [R_W-1:0]  SR_R   = R_W'(SAMPLE_RATE_HZ);
  localparam logic [R_W-1:0]  SR2_R  = R_W'(2 * SAMPLE_RATE_HZ);
  // B/SR in 0.32 fixed point
  localparam logic [63:0] F64 = (64'(B_VAL) << 32) / 64'(SAMPLE_RATE_HZ);
  localparam logic [31:0] F_C = F64[31:0];

  // stage 1: magnitude and direction
  logic              s1_valid;
  logic              s1_neg;
  logic [FREQ_W-1:0] s1_mag;

  // stage 2: products
  logic               s2_valid;
  logic               s2_neg;
  logic [FREQ_W-1:0]  s2_est;
  logic [R_W-1:0]     s2_mbh;
  logic [PHASE_W-1:0] s2_ma;

  // stage 3: remainder
  logic               s3_valid;
  logic               s3_neg;
  logic [FREQ_W-1:0]  s3_est;
  logic [R_W-1:0]     s3_rem;
  logic [PHASE_W-1:0] s3_ma;

  logic [FREQ_W+31:0]      prod_f;
  logic [FREQ_W+B_W-1:0]   prod_b;
  logic [FREQ_W+A_W-1:0]   prod_a;
  logic [FREQ_W+SR_W-1:0]  prod_sr;
  logic [1:0]              corr;

  assign prod_f  = s1_mag * F_C;
  assign prod_b  = s1_mag * B_C;
  assign prod_a  = s1_mag * A_C;
  assign prod_sr = s2_est * SR_C;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= in_take;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_neg <= freq[FREQ_W-1];
    s1_mag <= freq[FREQ_W-1] ? FREQ_W'(-freq) : FREQ_W'(freq);

    s2_neg <= s1_neg;
    s2_est <= prod_f[FREQ_W+31:32];
    s2_mbh <= R_W'(prod_b) + HALF_C;
    s2_ma  <= PHASE_W'(prod_a);

    // true remainder stays below three times the rate, so low bits suffice
    s3_neg <= s2_neg;
    s3_est <= s2_est;
    s3_rem <= s2_mbh - R_W'(prod_sr);
    s3_ma  <= s2_ma;
  end

  always_comb begin
    if (s3_rem >= SR2_R) begin
      corr = 2'd2;
    end else if (s3_rem >= SR_R) begin
      corr = 2'd1;
    end else begin
      corr = 2'd0;
    end
  end

  assign step_valid     = s3_valid;
  assign step_item.neg  = s3_neg;
  assign step_item.step = s3_ma + PHASE_W'(s3_est) + PHASE_W'(corr);
  assign inflight       = 2'(s1_valid) + 2'(s2_valid) + 2'(s3_valid);

endmodule

[sv/mwo_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwo_back
// Phase accumulator and the four waveform generators.
// ----------------------------------------------------------------------------
module mwo_back
  import mwo_pkg::*;
#(
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step_avail,
  input  step_t                         step_item,
  input  logic [$clog2(OUT_DEPTH):0]    out_count,
  output logic                          step_pop,
  output logic                          wave_valid,
  output wave_t                         wave
);

  localparam int TB = SINE_TABLE_BITS;
  localparam int N  = 1 << TB;
  localparam int CW = $clog2(OUT_DEPTH) + 1;

  typedef logic [ROM_W-1:0] rom_t [N];

  function automatic rom_t build_rom();
    rom_t        r;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] v;
    longint      sum;
    int          k;
    int          n;
    for (k = 0; k < N; k++) begin
      x    = (64'(k) * HALF_PI_Q30) >> TB;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (n = 1; n <= 6; n++) begin
        term = (term * x2) >> 30;
        term = term / 64'((2 * n) * (2 * n + 1));
        if ((n & 1) != 0) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      v = (64'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
      if (v > 64'd32767) begin
        v = 64'd32767;
      end
      r[k] = v[ROM_W-1:0];
    end
    return r;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  logic [PHASE_W-1:0] phase_acc;
  logic               b1_valid;

  logic               b2_valid;
  logic [LEVEL_W-1:0] b2_saw;
  logic [LEVEL_W-1:0] b2_square;
  logic [LEVEL_W-1:0] b2_tri;
  logic               b2_sine_neg;
  logic               b2_sine_peak;
  logic [ROM_W-1:0]   rom_q;

  logic [1:0]         quad;
  logic [TB-1:0]      idx;
  logic [TB-1:0]      rom_addr;
  logic [PHASE_W-1:0] ph_off;
  logic [PHASE_W-1:0] ph_dist;
  logic [16:0]        dist_hi;
  logic [CW:0]        held;
  logic [LEVEL_W-1:0] sine_mag;

  // take a step only when the result queue has a slot reserved for it
  assign held     = (CW+1)'(out_count) + (CW+1)'(b1_valid) + (CW+1)'(b2_valid);
  assign step_pop = step_avail && (held < (CW+1)'(OUT_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc <= '0;
      b1_valid  <= 1'b0;
      b2_valid  <= 1'b0;
    end else begin
      b1_valid <= step_pop;
      b2_valid <= b1_valid;
      if (step_pop) begin
        phase_acc <= step_item.neg ? phase_acc - step_item.step
                                   : phase_acc + step_item.step;
      end
    end
  end

  assign quad     = phase_acc[PHASE_W-1:PHASE_W-2];
  assign idx      = phase_acc[PHASE_W-3 -: TB];
  // mirror the index on the falling quadrants
  assign rom_addr = quad[0] ? TB'(-idx) : idx;

  assign ph_off   = phase_acc ^ {1'b1, {(PHASE_W-1){1'b0}}};
  assign ph_dist  = ph_off[PHASE_W-1] ? PHASE_W'(-ph_off) : ph_off;
  assign dist_hi  = ph_dist[PHASE_W-1:15];

  always_ff @(posedge clk) begin
    rom_q        <= SINE_ROM[rom_addr];
    b2_saw       <= phase_acc[PHASE_W-1:16] ^ 16'h8000;
    b2_square    <= (phase_acc <= 32'h8000_0000) ? LEVEL_MAX : LEVEL_MIN;
    // clamp +1 to the largest positive level
    b2_tri       <= dist_hi[16] ? LEVEL_MAX : (dist_hi[15:0] ^ 16'h8000);
    b2_sine_neg  <= quad[1];
    b2_sine_peak <= quad[0] && (idx == '0);
  end

  assign sine_mag = b2_sine_peak ? LEVEL_MAX : {1'b0, rom_q};

  assign wave_valid        = b2_valid;
  assign wave.saw_level    = b2_saw;
  assign wave.sine_level   = b2_sine_neg ? LEVEL_W'(-sine_mag) : sine_mag;
  assign wave.square_level = b2_square;
  assign wave.tri_level    = b2_tri;

endmodule

[sv/multi_waveform_oscillator_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_waveform_oscillator_core
// Numerically controlled oscillator with saw, sine, square and triangle out.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue: drive freq_sixteenth_hz and raise push; the
//   transaction is taken at an edge where push is high and full is low.
//   Each transaction is one sample tick and yields exactly one result.
//   Result side is a queue: while empty is low the oldest result sits on
//   saw_level, sine_level, square_level and tri_level; pop takes it.
//   From the accepting edge until empty falls for that result, a transaction
//   passes the phase step stages, the step queue, the phase add, the
//   registered sine table read and the result queue. Throughput is one
//   transaction per cycle, set by the single phase adder, while pop keeps up.
//   If the receiver stops popping, the 4-entry result queue fills, the back
//   end stops pulling steps, and full rises once the 8-entry step queue
//   plus the step pipeline hold 8 transactions; nothing is dropped.
//   Reset clears the phase to zero and empties both queues.
// ----------------------------------------------------------------------------
module multi_waveform_oscillator_core
  import mwo_pkg::*;
#(
  parameter int SAMPLE_RATE_HZ  = 48000,
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  logic signed [FREQ_W-1:0]  freq_sixteenth_hz,
  output logic                      empty,
  input  logic                      pop,
  output logic signed [LEVEL_W-1:0] saw_level,
  output logic signed [LEVEL_W-1:0] sine_level,
  output logic signed [LEVEL_W-1:0] square_level,
  output logic signed [LEVEL_W-1:0] tri_level
);

  localparam int MCW = $clog2(MID_DEPTH) + 1;
  localparam int OCW = $clog2(OUT_DEPTH) + 1;
  localparam int SW  = $bits(step_t);
  localparam int WW  = $bits(wave_t);

  logic           in_take;
  logic           step_valid;
  step_t          step_item;
  logic [1:0]     inflight;
  logic           mid_empty;
  logic [MCW-1:0] mid_count;
  step_t          mid_item;
  logic           step_pop;
  logic           wave_valid;
  wave_t          wave;
  wave_t          out_item;
  logic [OCW-1:0] out_count;
  logic [MCW:0]   held;
  logic           out_pop;

  // reserve a step queue slot for every transaction still in the front end
  assign held    = (MCW+1)'(mid_count) + (MCW+1)'(inflight);
  assign full    = (held >= (MCW+1)'(MID_DEPTH));
  assign in_take = push && !full;
  assign out_pop = pop && !empty;

  mwo_front #(
    .SAMPLE_RATE_HZ (SAMPLE_RATE_HZ)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_take    (in_take),
    .freq       (freq_sixteenth_hz),
    .step_valid (step_valid),
    .step_item  (step_item),
    .inflight   (inflight)
  );

  mwo_fifo #(
    .W     (SW),
    .DEPTH (MID_DEPTH)
  ) u_step_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (step_valid),
    .wr_data (step_item),
    .rd_en   (step_pop),
    .rd_data (mid_item),
    .empty   (mid_empty),
    .count   (mid_count)
  );

  mwo_back #(
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .step_avail (!mid_empty),
    .step_item  (mid_item),
    .out_count  (out_count),
    .step_pop   (step_pop),
    .wave_valid (wave_valid),
    .wave       (wave)
  );

  mwo_fifo #(
    .W     (WW),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wave_valid),
    .wr_data (wave),
    .rd_en   (out_pop),
    .rd_data (out_item),
    .empty   (empty),
    .count   (out_count)
  );

  assign saw_level    = out_item.saw_level;
  assign sine_level   = out_item.sine_level;
  assign square_level = out_item.square_level;
  assign tri_level    = out_item.tri_level;

  // step queue credit never overcommits
  a_mid_credit : assert property (@(posedge clk) disable iff (rst)
    held <= (MCW+1)'(MID_DEPTH))
    else $error("step queue credit overcommitted");

  // a result never lands in a full result queue
  a_out_room : assert property (@(posedge clk) disable iff (rst)
    wave_valid |-> (out_count < OCW'(OUT_DEPTH)))
    else $error("result written into full queue");

  // an accepted transaction is tracked by the front end next cycle
  a_take_tracked : assert property (@(posedge clk) disable iff (rst)
    in_take |=> (inflight != 2'd0))
    else $error("accepted transaction not tracked");

endmodule
